// ----- hw/rtl/lpi_pkg.sv -----
package lpi_pkg;

	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 4;

	localparam int DW     = COORD_BITS + 1;
	localparam int CW     = 2 * COORD_BITS + 1;
	localparam int DETW   = 2 * DW + 1;
	localparam int NW     = CW + DW + 1;
	localparam int OUT_W  = 32;

	localparam logic [NW-1:0] LIMIT_POS = NW'((64'd1 << (OUT_W - 1)) - 64'd1);
	localparam logic [NW-1:0] LIMIT_NEG = NW'(64'd1 << (OUT_W - 1));

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_VERTICAL  = 2'd1,
		ST_PARALLEL  = 2'd2,
		ST_SATURATED = 2'd3
	} status_t;

	typedef struct packed {
		logic vert;
		logic par;
		logic neg_x;
		logic neg_y;
	} side_t;

endpackage

// ----- hw/rtl/lpi_div.sv -----
module lpi_div import lpi_pkg::*; (
	input  logic            clk,
	input  logic            en,
	input  logic [NW-1:0]   num_mag,
	input  logic [DETW-1:0] den_mag,
	output logic [NW-1:0]   quo
);

	logic [DETW-1:0] rem_s [NW];
	logic [NW-1:0]   num_s [NW];
	logic [NW-1:0]   quo_s [NW];
	logic [DETW-1:0] den_s [NW];

	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic [DETW-1:0] rem_p;
		logic [NW-1:0]   num_p;
		logic [NW-1:0]   quo_p;
		logic [DETW-1:0] den_p;
		logic [DETW:0]   trial;
		logic            qbit;

		if (i == 0) begin : g_first
			assign rem_p = '0;
			assign num_p = num_mag;
			assign quo_p = '0;
			assign den_p = den_mag;
		end else begin : g_next
			assign rem_p = rem_s[i-1];
			assign num_p = num_s[i-1];
			assign quo_p = quo_s[i-1];
			assign den_p = den_s[i-1];
		end

		assign trial = {rem_p, num_p[NW-1]};
		assign qbit  = (trial >= {1'b0, den_p});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= qbit ? DETW'(trial - {1'b0, den_p}) : trial[DETW-1:0];
				num_s[i] <= {num_p[NW-2:0], 1'b0};
				quo_s[i] <= {quo_p[NW-2:0], qbit};
				den_s[i] <= den_p;
			end
		end
	end

	assign quo = quo_s[NW-1];

endmodule

// ----- hw/rtl/line_pair_intersection.sv -----
// Pipeline: an accepted transaction passes through five arithmetic stages, a
// 51-stage restoring divider and an output register on its way to the result.
// Throughput: one transaction per cycle; the whole pipeline holds while a result is
// stalled at the output.
// Reset clears all valid bits asynchronously; data registers are not reset.
module line_pair_intersection import lpi_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic signed [COORD_BITS-1:0] first_start_x,
	input  logic signed [COORD_BITS-1:0] first_start_y,
	input  logic signed [COORD_BITS-1:0] first_end_x,
	input  logic signed [COORD_BITS-1:0] first_end_y,
	input  logic signed [COORD_BITS-1:0] second_start_x,
	input  logic signed [COORD_BITS-1:0] second_start_y,
	input  logic signed [COORD_BITS-1:0] second_end_x,
	input  logic signed [COORD_BITS-1:0] second_end_y,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic signed [OUT_W-1:0]      cross_x,
	output logic signed [OUT_W-1:0]      cross_y,
	output logic [1:0]                   status
);

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic v_div [NW];
	side_t side_div [NW];

	logic signed [DW-1:0]     dx0_s1, dy0_s1, dx1_s1, dy1_s1;
	logic signed [CW-2:0]     pa0_s1, pb0_s1, pa1_s1, pb1_s1;
	logic signed [DW-1:0]     dx0_s2, dy0_s2, dx1_s2, dy1_s2;
	logic signed [CW-1:0]     c0_s2, c1_s2;
	logic signed [DETW-2:0]   da_s2, db_s2;
	logic                     vert_s2, vert_s3, vert_s4, vert_s5;
	logic signed [DETW-1:0]   det_s3;
	logic signed [NW-2:0]     nxa_s3, nxb_s3, nya_s3, nyb_s3;
	logic signed [DETW-1:0]   det_s4;
	logic signed [NW-1:0]     nx_s4, ny_s4;
	logic                     par_s4, par_s5;
	logic [NW-1:0]            nxm_s5, nym_s5;
	logic [DETW-1:0]          detm_s5;
	logic                     nx_neg_s5, ny_neg_s5, det_neg_s5;
	logic [NW-1:0]            qx, qy;
	side_t                    side_in;
	side_t                    side_o;
	logic                     sat_x, sat_y;
	logic [OUT_W-1:0]         val_x, val_y;

	assign adv       = !(res_valid && res_stall);
	assign req_stall = !adv;

	always_ff @(posedge clk) begin
		if (adv) begin
			dx0_s1 <= DW'(first_end_x) - DW'(first_start_x);
			dy0_s1 <= DW'(first_end_y) - DW'(first_start_y);
			dx1_s1 <= DW'(second_end_x) - DW'(second_start_x);
			dy1_s1 <= DW'(second_end_y) - DW'(second_start_y);
			pa0_s1 <= (CW-1)'(first_end_x) * (CW-1)'(first_start_y);
			pb0_s1 <= (CW-1)'(first_start_x) * (CW-1)'(first_end_y);
			pa1_s1 <= (CW-1)'(second_end_x) * (CW-1)'(second_start_y);
			pb1_s1 <= (CW-1)'(second_start_x) * (CW-1)'(second_end_y);

			dx0_s2 <= dx0_s1;
			dy0_s2 <= dy0_s1;
			dx1_s2 <= dx1_s1;
			dy1_s2 <= dy1_s1;
			c0_s2  <= CW'(pa0_s1) - CW'(pb0_s1);
			c1_s2  <= CW'(pa1_s1) - CW'(pb1_s1);
			da_s2  <= (DETW-1)'(dy0_s1) * (DETW-1)'(dx1_s1);
			db_s2  <= (DETW-1)'(dy1_s1) * (DETW-1)'(dx0_s1);
			vert_s2 <= (dx0_s1 == '0) || (dx1_s1 == '0);

			det_s3  <= DETW'(da_s2) - DETW'(db_s2);
			nxa_s3  <= (NW-1)'(c1_s2) * (NW-1)'(dx0_s2);
			nxb_s3  <= (NW-1)'(c0_s2) * (NW-1)'(dx1_s2);
			nya_s3  <= (NW-1)'(c1_s2) * (NW-1)'(dy0_s2);
			nyb_s3  <= (NW-1)'(c0_s2) * (NW-1)'(dy1_s2);
			vert_s3 <= vert_s2;

			det_s4  <= det_s3;
			nx_s4   <= NW'(nxa_s3) - NW'(nxb_s3);
			ny_s4   <= NW'(nya_s3) - NW'(nyb_s3);
			par_s4  <= (det_s3 == '0);
			vert_s4 <= vert_s3;

			nx_neg_s5  <= nx_s4[NW-1];
			ny_neg_s5  <= ny_s4[NW-1];
			det_neg_s5 <= det_s4[DETW-1];
			nxm_s5     <= nx_s4[NW-1] ? NW'(-nx_s4) : NW'(nx_s4);
			nym_s5     <= ny_s4[NW-1] ? NW'(-ny_s4) : NW'(ny_s4);
			detm_s5    <= det_s4[DETW-1] ? DETW'(-det_s4) : DETW'(det_s4);
			par_s5     <= par_s4;
			vert_s5    <= vert_s4;
		end
	end

	lpi_div u_div_x (
		.clk     (clk),
		.en      (adv),
		.num_mag (nxm_s5),
		.den_mag (detm_s5),
		.quo     (qx)
	);

	lpi_div u_div_y (
		.clk     (clk),
		.en      (adv),
		.num_mag (nym_s5),
		.den_mag (detm_s5),
		.quo     (qy)
	);

	assign side_in.vert  = vert_s5;
	assign side_in.par   = par_s5;
	assign side_in.neg_x = nx_neg_s5 ^ det_neg_s5;
	assign side_in.neg_y = ny_neg_s5 ^ det_neg_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_div[0] <= side_in;
			for (int i = 1; i < NW; i++) begin
				side_div[i] <= side_div[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			for (int i = 0; i < NW; i++) begin
				v_div[i] <= 1'b0;
			end
			res_valid <= 1'b0;
		end else if (adv) begin
			v_s1 <= req_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_div[0] <= v_s5;
			for (int i = 1; i < NW; i++) begin
				v_div[i] <= v_div[i-1];
			end
			res_valid <= v_div[NW-1];
		end
	end

	assign side_o = side_div[NW-1];
	assign sat_x  = qx > (side_o.neg_x ? LIMIT_NEG : LIMIT_POS);
	assign sat_y  = qy > (side_o.neg_y ? LIMIT_NEG : LIMIT_POS);

	always_comb begin
		if (sat_x) begin
			val_x = side_o.neg_x ? LIMIT_NEG[OUT_W-1:0] : LIMIT_POS[OUT_W-1:0];
		end else begin
			val_x = side_o.neg_x ? OUT_W'(-qx) : qx[OUT_W-1:0];
		end
		if (sat_y) begin
			val_y = side_o.neg_y ? LIMIT_NEG[OUT_W-1:0] : LIMIT_POS[OUT_W-1:0];
		end else begin
			val_y = side_o.neg_y ? OUT_W'(-qy) : qy[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (side_o.vert) begin
				cross_x <= '0;
				cross_y <= '0;
				status  <= ST_VERTICAL;
			end else if (side_o.par) begin
				cross_x <= '0;
				cross_y <= '0;
				status  <= ST_PARALLEL;
			end else begin
				cross_x <= val_x;
				cross_y <= val_y;
				status  <= (sat_x || sat_y) ? ST_SATURATED : ST_OK;
			end
		end
	end

	a_special_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == ST_VERTICAL || status == ST_PARALLEL)
		|-> (cross_x == '0 && cross_y == '0))
		else $error("Degenerate result carries a nonzero coordinate.");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> v_s1)
		else $error("Accepted transaction did not enter the first stage.");

	a_div_entry: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s5 |=> v_div[0])
		else $error("Transaction lost between the front end and the divider.");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(cross_x) && $stable(status))
		else $error("Stalled result changed.");

endmodule

// ----- bench/line_pair_intersection_test.sv -----
module line_pair_intersection_test;
	import lpi_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [0:7][COORD_BITS-1:0] seg_pair_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] x;
		logic signed [OUT_W-1:0] y;
		status_t st;
	} crossing_t;

	typedef struct packed {
		seg_pair_t pair;
		bit typed;
		crossing_t want;
	} vec_t;

	localparam logic signed [OUT_W-1:0] ZERO32 = '0;
	localparam coord_t CMAX = coord_t'(32767);
	localparam coord_t CMIN = coord_t'(-32768);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	coord_t first_start_x = '0, first_start_y = '0, first_end_x = '0, first_end_y = '0;
	coord_t second_start_x = '0, second_start_y = '0, second_end_x = '0, second_end_y = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic signed [OUT_W-1:0] cross_x, cross_y;
	logic [1:0] status;

	bit drive_typed = 1'b0;
	crossing_t drive_want;
	crossing_t pending_crossings[$];
	int mismatch_count = 0;
	int idle_pct = 0;
	int stall_pct = 0;

	line_pair_intersection u_dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic crossing_t predict_crossing(seg_pair_t p);
		longint v[8];
		longint dx0, dy0, dx1, dy1, c0, c1, det, qx, qy;
		crossing_t r;
		for (int i = 0; i < 8; i++) begin
			v[i] = longint'(coord_t'(p[i]));
		end
		dx0 = v[2] - v[0];
		dy0 = v[3] - v[1];
		dx1 = v[6] - v[4];
		dy1 = v[7] - v[5];
		c0 = v[2] * v[1] - v[0] * v[3];
		c1 = v[6] * v[5] - v[4] * v[7];
		det = dy0 * dx1 - dy1 * dx0;
		r.x = '0;
		r.y = '0;
		r.st = ST_OK;
		if (dx0 == 0 || dx1 == 0) begin
			r.st = ST_VERTICAL;
		end else if (det == 0) begin
			r.st = ST_PARALLEL;
		end else begin
			qx = (c1 * dx0 - c0 * dx1) / det;
			qy = (c1 * dy0 - c0 * dy1) / det;
			if (qx > 64'sd2147483647 || qx < -64'sd2147483648 ||
			    qy > 64'sd2147483647 || qy < -64'sd2147483648) begin
				r.st = ST_SATURATED;
			end
			if (qx > 64'sd2147483647) qx = 64'sd2147483647;
			if (qx < -64'sd2147483648) qx = -64'sd2147483648;
			if (qy > 64'sd2147483647) qy = 64'sd2147483647;
			if (qy < -64'sd2147483648) qy = -64'sd2147483648;
			r.x = qx[OUT_W-1:0];
			r.y = qy[OUT_W-1:0];
		end
		return r;
	endfunction

	always @(posedge clk) begin
		if (req_valid && !req_stall) begin
			if (drive_typed) begin
				pending_crossings.push_back(drive_want);
			end else begin
				pending_crossings.push_back(predict_crossing({first_start_x, first_start_y,
					first_end_x, first_end_y, second_start_x, second_start_y,
					second_end_x, second_end_y}));
			end
		end
	end

	always @(posedge clk) begin
		crossing_t w;
		if (res_valid && !res_stall) begin
			if (pending_crossings.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("unexpected result: x=%0d y=%0d status=%0d", cross_x, cross_y,
						status);
				end
			end else begin
				w = pending_crossings.pop_front();
				if (cross_x !== w.x || cross_y !== w.y || status !== w.st) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("mismatch: expected x=%0d y=%0d status=%0d, got x=%0d y=%0d status=%0d",
							w.x, w.y, w.st, cross_x, cross_y, status);
					end
				end
			end
		end
	end

	always @(negedge clk) begin
		res_stall = ($urandom_range(99) < stall_pct);
	end

	task automatic send_pair(seg_pair_t p, bit typed, crossing_t want);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			req_valid = 1'b0;
		end
		@(negedge clk);
		{first_start_x, first_start_y, first_end_x, first_end_y,
			second_start_x, second_start_y, second_end_x, second_end_y} = p;
		drive_typed = typed;
		drive_want = want;
		req_valid = 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic hold_off();
		@(negedge clk);
		req_valid = 1'b0;
	endtask

	function automatic coord_t pick_extreme();
		case ($urandom_range(4))
			0: return CMIN;
			1: return CMAX;
			2: return coord_t'(0);
			3: return coord_t'(-1);
			default: return coord_t'(1);
		endcase
	endfunction

	function automatic coord_t small_coord(int span);
		return coord_t'(int'($urandom_range(2 * span)) - span);
	endfunction

	function automatic seg_pair_t random_pair();
		seg_pair_t p;
		int k;
		coord_t ddx, ddy;
		for (int i = 0; i < 8; i++) begin
			p[i] = coord_t'($urandom());
		end
		case ($urandom_range(9))
			4, 5: begin
				for (int i = 0; i < 8; i++) p[i] = small_coord(400);
			end
			6: begin
				if ($urandom_range(1)) p[2] = p[0];
				else p[6] = p[4];
			end
			7: begin
				for (int i = 0; i < 8; i++) p[i] = small_coord(1000);
				k = int'($urandom_range(6)) - 3;
				if (k == 0) k = 2;
				p[6] = coord_t'(p[4] + k * (p[2] - p[0]));
				p[7] = coord_t'(p[5] + k * (p[3] - p[1]));
			end
			8: begin
				ddx = small_coord(30000);
				ddy = small_coord(200);
				p[0] = small_coord(500);
				p[1] = coord_t'($urandom());
				p[2] = coord_t'(p[0] + ddx);
				p[3] = coord_t'(p[1] + ddy);
				p[4] = coord_t'(p[0] + small_coord(500));
				p[5] = coord_t'($urandom());
				p[6] = coord_t'(p[4] + ddx);
				p[7] = coord_t'(p[5] + ddy + small_coord(1));
			end
			9: begin
				for (int i = 0; i < 8; i++) p[i] = pick_extreme();
			end
			default: ;
		endcase
		return p;
	endfunction

	vec_t directed[] = '{
		'{{8{coord_t'(0)}}, 1'b1, '{ZERO32, ZERO32, ST_VERTICAL}},
		'{{CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN}, 1'b1,
			'{ZERO32, ZERO32, ST_VERTICAL}},
		'{{coord_t'(5), CMAX, coord_t'(5), CMIN, coord_t'(3), CMAX, coord_t'(0), CMIN}, 1'b1,
			'{ZERO32, ZERO32, ST_VERTICAL}},
		'{{coord_t'(7), coord_t'(3), coord_t'(-7), coord_t'(-3), coord_t'(9), CMAX,
			coord_t'(9), CMIN}, 1'b1, '{ZERO32, ZERO32, ST_VERTICAL}},
		'{{coord_t'(100), CMAX, coord_t'(0), CMIN, coord_t'(100), coord_t'(0), coord_t'(0),
			coord_t'(0)}, 1'b0, '0},
		'{{CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, CMAX, CMIN}, 1'b1,
			'{ZERO32, ZERO32, ST_PARALLEL}},
		'{{coord_t'(32), coord_t'(32), coord_t'(16), coord_t'(16), coord_t'(32), coord_t'(32),
			coord_t'(16), coord_t'(16)}, 1'b1, '{ZERO32, ZERO32, ST_PARALLEL}},
		'{{coord_t'(48), coord_t'(32), coord_t'(16), coord_t'(16), coord_t'(48), coord_t'(32),
			coord_t'(16), coord_t'(16)}, 1'b1, '{ZERO32, ZERO32, ST_PARALLEL}},
		'{{coord_t'(16), coord_t'(-16), coord_t'(-16), coord_t'(16), coord_t'(16),
			coord_t'(16), coord_t'(-16), coord_t'(-16)}, 1'b1, '{ZERO32, ZERO32, ST_OK}},
		'{{coord_t'(-16), coord_t'(-16), coord_t'(16), coord_t'(16), coord_t'(-16),
			coord_t'(16), coord_t'(16), coord_t'(-16)}, 1'b1, '{ZERO32, ZERO32, ST_OK}},
		'{{coord_t'(32766), CMAX, CMIN, CMIN, coord_t'(-32767), CMAX, CMAX, CMIN},
			1'b0, '0},
		'{{coord_t'(32767), coord_t'(32766), coord_t'(-32768), coord_t'(32767),
			coord_t'(32767), coord_t'(-32767), coord_t'(-32768), coord_t'(-32768)}, 1'b0, '0},
		'{{coord_t'(32767), coord_t'(32767), coord_t'(-32768), coord_t'(-32768),
			coord_t'(32767), coord_t'(32766), coord_t'(-32768), coord_t'(-32768)}, 1'b0, '0},
		'{{coord_t'(3), coord_t'(-5), coord_t'(17), coord_t'(2), coord_t'(-9), coord_t'(11),
			coord_t'(4), coord_t'(-6)}, 1'b0, '0},
		'{{CMIN, coord_t'(1), CMAX, coord_t'(-1), coord_t'(1), CMIN, coord_t'(-1), CMAX},
			1'b0, '0},
		'{{coord_t'(-1), coord_t'(-1), coord_t'(1), coord_t'(0), coord_t'(0), coord_t'(1),
			coord_t'(-1), coord_t'(0)}, 1'b0, '0}
	};

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		foreach (directed[i]) begin
			send_pair(directed[i].pair, directed[i].typed, directed[i].want);
		end
		hold_off();
		while (pending_crossings.size() != 0) @(posedge clk);
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 58; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 58; end
				default: begin idle_pct = 38; stall_pct = 38; end
			endcase
			repeat (435) begin
				send_pair(random_pair(), 1'b0, '0);
			end
		end
		hold_off();
		idle_pct = 0;
		stall_pct = 0;
		while (pending_crossings.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
		if (mismatch_count == 0 && pending_crossings.size() == 0) begin
			$display("line_pair_intersection test passed");
		end else begin
			$display("line_pair_intersection test failed");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("line_pair_intersection test failed");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/lpi_pkg.sv
hw/rtl/lpi_div.sv
hw/rtl/line_pair_intersection.sv
bench/line_pair_intersection_test.sv
